// ----- src/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg - shared types and helpers for the look-at view matrix block
// Vector types at the widths used between stages, the result record and the
// rounding and saturation helpers of the translation path.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Quotient bits of a unit component: |q| <= 65536
  localparam int QBits = 17;
  // The largest normalized magnitude sits in [2^29, 2^30)
  localparam int MagBits = 30;
  localparam int RootBits = 31;
  localparam int SumBits = 62;
  localparam int NumBits = 47;

  // Unit vector, Q16.16 in [-65536, 65536]
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } uvec_t;

  // Exact cross product of two unit vectors, Q32.32
  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [34:0] z;
  } cvec_t;

  // Input coordinate triple
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } evec_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] camera_up_x;
    logic signed [31:0] camera_up_y;
    logic signed [31:0] camera_up_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] shift_side;
    logic signed [31:0] shift_up;
    logic signed [31:0] shift_forward;
  } res_t;

  // Round a Q32.32 value to Q16.16, half away from zero
  function automatic logic signed [37:0] rnd16(input logic signed [53:0] v);
    logic [53:0] m;
    logic [37:0] r;
    m = v[53] ? 54'(-v) : 54'(v);
    r = 38'((m + 54'(32768)) >> 16);
    return v[53] ? -$signed(r) : $signed(r);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ----- src/lav_if.sv -----
// ----------------------------------------------------------------------------
// lav_if - item channels of the look-at view matrix block
// Valid/ready channels: eye, target and up on the way in; the view matrix
// rows and translations on the way out.
// ----------------------------------------------------------------------------
interface lav_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

interface lav_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] side_x;
  logic signed [31:0] side_y;
  logic signed [31:0] side_z;
  logic signed [31:0] camera_up_x;
  logic signed [31:0] camera_up_y;
  logic signed [31:0] camera_up_z;
  logic signed [31:0] back_x;
  logic signed [31:0] back_y;
  logic signed [31:0] back_z;
  logic signed [31:0] shift_side;
  logic signed [31:0] shift_up;
  logic signed [31:0] shift_forward;

  modport source (output valid, side_x, side_y, side_z, camera_up_x, camera_up_y,
                  camera_up_z, back_x, back_y, back_z, shift_side, shift_up,
                  shift_forward, input ready);
  modport sink (input valid, side_x, side_y, side_z, camera_up_x, camera_up_y,
                camera_up_z, back_x, back_y, back_z, shift_side, shift_up,
                shift_forward, output ready);
endinterface

// ----- src/lav_isqrt.sv -----
// ----------------------------------------------------------------------------
// lav_isqrt - pipelined integer square root
// Floor square root of a 62-bit value, one root bit per register stage.
// ----------------------------------------------------------------------------
module lav_isqrt #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vin,
  input  logic [lav_pkg::SumBits-1:0]   n,
  input  logic [SW-1:0]                 side_in,
  output logic                          vout,
  output logic [lav_pkg::RootBits-1:0]  root,
  output logic [SW-1:0]                 side_out
);
  import lav_pkg::*;

  logic [SumBits-1:0]  rem_q  [RootBits];
  logic [RootBits-1:0] root_q [RootBits];
  logic [SW-1:0]       side_q [RootBits];
  logic                v_q    [RootBits];

  for (genvar k = 0; k < RootBits; k++) begin : g_step
    localparam int I = RootBits - 1 - k;
    logic [SumBits-1:0]  rem_i;
    logic [RootBits-1:0] root_i;
    logic [SW-1:0]       side_i;
    logic                v_i;
    logic [SumBits:0]    trial;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_i  = n;
      assign root_i = '0;
      assign side_i = side_in;
      assign v_i    = vin;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign side_i = side_q[k-1];
      assign v_i    = v_q[k-1];
    end

    // (r + 2^I)^2 - r^2 = r * 2^(I+1) + 2^(2I)
    assign trial = ((SumBits+1)'(root_i) << (I + 1)) | ((SumBits+1)'(1) << (2 * I));
    assign take  = {1'b0, rem_i} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? rem_i - trial[SumBits-1:0] : rem_i;
        root_q[k] <= take ? (root_i | (RootBits'(1) << I)) : root_i;
        side_q[k] <= side_i;
      end
    end
  end

  assign vout     = v_q[RootBits-1];
  assign root     = root_q[RootBits-1];
  assign side_out = side_q[RootBits-1];

endmodule

// ----- src/lav_norm.sv -----
// ----------------------------------------------------------------------------
// lav_norm - pipelined vector normalization
// Scales three magnitudes, the largest into [2^29, 2^30), takes the root of
// the sum of squares and divides each by it, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int W  = 33,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  logic [W-1:0]   vx,
  input  logic [W-1:0]   vy,
  input  logic [W-1:0]   vz,
  input  logic [SW-1:0]  side_in,
  output logic           vout,
  output lav_pkg::uvec_t r,
  output logic [SW-1:0]  side_out
);
  import lav_pkg::*;

  localparam int PW  = $clog2(W);
  localparam int QSW = 3 * MagBits + 4 + SW;

  logic [W-1:0] v_in [3];
  assign v_in[0] = vx;
  assign v_in[1] = vy;
  assign v_in[2] = vz;

  // stage 1: sign and magnitude
  logic          v1;
  logic [2:0]    neg1;
  logic [W-1:0]  mag1 [3];
  logic [W-1:0]  or1;
  logic [SW-1:0] side1;
  // stage 2: leading one of the largest magnitude
  logic          v2;
  logic [2:0]    neg2;
  logic [W-1:0]  mag2 [3];
  logic [PW-1:0] pos2;
  logic          zero2;
  logic [SW-1:0] side2;
  // stage 3: scaled magnitudes
  logic               v3;
  logic [2:0]         neg3;
  logic [MagBits-1:0] m3 [3];
  logic               zero3;
  logic [SW-1:0]      side3;
  // stage 4: squares
  logic                 v4;
  logic [2:0]           neg4;
  logic [MagBits-1:0]   m4 [3];
  logic [2*MagBits-1:0] sq4 [3];
  logic                 zero4;
  logic [SW-1:0]        side4;
  // stage 5: sum of squares
  logic               v5;
  logic [2:0]         neg5;
  logic [MagBits-1:0] m5 [3];
  logic [SumBits-1:0] sum5;
  logic               zero5;
  logic [SW-1:0]      side5;

  logic [PW-1:0] pos_c;
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < W; i++) begin
      if (or1[i]) begin
        pos_c = PW'(i);
      end
    end
  end

  logic [W+MagBits-2:0] shifted [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = {mag2[c], (MagBits-1)'(0)} >> pos2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        neg1[c] <= v_in[c][W-1];
        mag1[c] <= v_in[c][W-1] ? (~v_in[c] + W'(1)) : v_in[c];
        mag2[c] <= mag1[c];
        m3[c]   <= shifted[c][MagBits-1:0];
        m4[c]   <= m3[c];
        sq4[c]  <= m3[c] * m3[c];
        m5[c]   <= m4[c];
      end
      or1   <= (v_in[0][W-1] ? (~v_in[0] + W'(1)) : v_in[0])
             | (v_in[1][W-1] ? (~v_in[1] + W'(1)) : v_in[1])
             | (v_in[2][W-1] ? (~v_in[2] + W'(1)) : v_in[2]);
      side1 <= side_in;
      neg2  <= neg1;
      pos2  <= pos_c;
      zero2 <= or1 == '0;
      side2 <= side1;
      neg3  <= neg2;
      zero3 <= zero2;
      side3 <= side2;
      neg4  <= neg3;
      zero4 <= zero3;
      side4 <= side3;
      neg5  <= neg4;
      zero5 <= zero4;
      side5 <= side4;
      sum5  <= SumBits'(sq4[0]) + SumBits'(sq4[1]) + SumBits'(sq4[2]);
    end
  end

  // root of the sum, magnitudes and flags riding alongside
  logic                vq;
  logic [RootBits-1:0] len_q;
  logic [QSW-1:0]      qside;

  lav_isqrt #(.SW(QSW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v5),
    .n        (sum5),
    .side_in  ({m5[0], m5[1], m5[2], neg5, zero5, side5}),
    .vout     (vq),
    .root     (len_q),
    .side_out (qside)
  );

  logic [MagBits-1:0] mq [3];
  logic [2:0]         negq;
  logic               zeroq;
  logic [SW-1:0]      sideq;
  assign {mq[0], mq[1], mq[2], negq, zeroq, sideq} = qside;

  // stage 6: dividend with half the divisor added for rounding
  logic                v6;
  logic [NumBits-1:0]  num6 [3];
  logic [RootBits-1:0] len6;
  logic [2:0]          neg6;
  logic                zero6;
  logic [SW-1:0]       side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num6[c] <= {1'b0, mq[c], 16'b0} + NumBits'(len_q >> 1);
      end
      len6  <= len_q;
      neg6  <= negq;
      zero6 <= zeroq;
      side6 <= sideq;
    end
  end

  // restoring division, one quotient bit per stage
  logic [NumBits-1:0]  drem  [QBits][3];
  logic [QBits-1:0]    dq    [QBits][3];
  logic [RootBits-1:0] dlen  [QBits];
  logic [2:0]          dneg  [QBits];
  logic                dzero [QBits];
  logic [SW-1:0]       dside [QBits];
  logic                dv    [QBits];

  for (genvar k = 0; k < QBits; k++) begin : g_div
    localparam int J = QBits - 1 - k;
    logic [NumBits-1:0]  rem_i [3];
    logic [QBits-1:0]    q_i   [3];
    logic [RootBits-1:0] len_i;
    logic [2:0]          neg_i;
    logic                zero_i;
    logic [SW-1:0]       side_i;
    logic                v_i;

    if (k == 0) begin : g_first
      assign rem_i  = num6;
      assign q_i[0] = '0;
      assign q_i[1] = '0;
      assign q_i[2] = '0;
      assign len_i  = len6;
      assign neg_i  = neg6;
      assign zero_i = zero6;
      assign side_i = side6;
      assign v_i    = v6;
    end else begin : g_next
      assign rem_i  = drem[k-1];
      assign q_i    = dq[k-1];
      assign len_i  = dlen[k-1];
      assign neg_i  = dneg[k-1];
      assign zero_i = dzero[k-1];
      assign side_i = dside[k-1];
      assign v_i    = dv[k-1];
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [NumBits:0] dd;
      logic             take;
      assign dd   = (NumBits+1)'(len_i) << J;
      assign take = {1'b0, rem_i[c]} >= dd;

      always_ff @(posedge clk) begin
        if (en) begin
          drem[k][c] <= take ? rem_i[c] - dd[NumBits-1:0] : rem_i[c];
          dq[k][c]   <= take ? (q_i[c] | (QBits'(1) << J)) : q_i[c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dlen[k]  <= len_i;
        dneg[k]  <= neg_i;
        dzero[k] <= zero_i;
        dside[k] <= side_i;
      end
    end
  end

  // restore the signs; a zero-length vector gives zero
  logic signed [17:0] res_c [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dzero[QBits-1]) begin
        res_c[c] = '0;
      end else if (dneg[QBits-1][c]) begin
        res_c[c] = -$signed({1'b0, dq[QBits-1][c]});
      end else begin
        res_c[c] = $signed({1'b0, dq[QBits-1][c]});
      end
    end
  end

  assign r.x      = res_c[0];
  assign r.y      = res_c[1];
  assign r.z      = res_c[2];
  assign vout     = dv[QBits-1];
  assign side_out = dside[QBits-1];

endmodule

// ----- src/lav_cross.sv -----
// ----------------------------------------------------------------------------
// lav_cross - exact cross product of two unit vectors
// Six products in one stage, the differences in the next.
// ----------------------------------------------------------------------------
module lav_cross #(
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  lav_pkg::uvec_t a,
  input  lav_pkg::uvec_t b,
  input  logic [SW-1:0]  side_in,
  output logic           vout,
  output lav_pkg::cvec_t c,
  output logic [SW-1:0]  side_out
);
  import lav_pkg::*;

  logic               v1;
  logic signed [35:0] p [6];
  logic [SW-1:0]      side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      vout <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]     <= a.y * b.z;
      p[1]     <= a.z * b.y;
      p[2]     <= a.z * b.x;
      p[3]     <= a.x * b.z;
      p[4]     <= a.x * b.y;
      p[5]     <= a.y * b.x;
      side1    <= side_in;
      c.x      <= 35'(p[0] - p[1]);
      c.y      <= 35'(p[2] - p[3]);
      c.z      <= 35'(p[4] - p[5]);
      side_out <= side1;
    end
  end

endmodule

// ----- src/lav_xform.sv -----
// ----------------------------------------------------------------------------
// lav_xform - camera up rounding and translation dots
// Rounds s x f to the camera up vector, forms the three dots with the eye,
// rounds them, negates side and up, saturates into the result register.
// ----------------------------------------------------------------------------
module lav_xform (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  lav_pkg::cvec_t c,
  input  lav_pkg::uvec_t s,
  input  lav_pkg::uvec_t f,
  input  lav_pkg::evec_t eye,
  output logic           vout,
  output lav_pkg::res_t  res
);
  import lav_pkg::*;

  logic v1, v2, v3;
  // stage 1
  logic signed [18:0] u1 [3];
  uvec_t              s1, f1;
  evec_t              e1;
  // stage 2
  logic signed [50:0] ps2 [3];
  logic signed [50:0] pu2 [3];
  logic signed [50:0] pf2 [3];
  logic signed [18:0] u2 [3];
  uvec_t              s2, f2;
  // stage 3
  logic signed [52:0] ds3, du3, df3;
  logic signed [18:0] u3 [3];
  uvec_t              s3, f3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      v3   <= v2;
      vout <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1[0] <= 19'(rnd16(54'(c.x)));
      u1[1] <= 19'(rnd16(54'(c.y)));
      u1[2] <= 19'(rnd16(54'(c.z)));
      s1    <= s;
      f1    <= f;
      e1    <= eye;

      ps2[0] <= s1.x * e1.x;
      ps2[1] <= s1.y * e1.y;
      ps2[2] <= s1.z * e1.z;
      pu2[0] <= u1[0] * e1.x;
      pu2[1] <= u1[1] * e1.y;
      pu2[2] <= u1[2] * e1.z;
      pf2[0] <= f1.x * e1.x;
      pf2[1] <= f1.y * e1.y;
      pf2[2] <= f1.z * e1.z;
      u2     <= u1;
      s2     <= s1;
      f2     <= f1;

      ds3 <= 53'(ps2[0]) + 53'(ps2[1]) + 53'(ps2[2]);
      du3 <= 53'(pu2[0]) + 53'(pu2[1]) + 53'(pu2[2]);
      df3 <= 53'(pf2[0]) + 53'(pf2[1]) + 53'(pf2[2]);
      u3  <= u2;
      s3  <= s2;
      f3  <= f2;

      res.side_x        <= 32'(s3.x);
      res.side_y        <= 32'(s3.y);
      res.side_z        <= 32'(s3.z);
      res.camera_up_x   <= 32'(u3[0]);
      res.camera_up_y   <= 32'(u3[1]);
      res.camera_up_z   <= 32'(u3[2]);
      res.back_x        <= -(32'(f3.x));
      res.back_y        <= -(32'(f3.y));
      res.back_z        <= -(32'(f3.z));
      res.shift_side    <= sat32(-rnd16(54'(ds3)));
      res.shift_up      <= sat32(-rnd16(54'(du3)));
      res.shift_forward <= sat32(rnd16(54'(df3)));
    end
  end

endmodule

// ----- src/look_at_view_matrix.sv -----
// ----------------------------------------------------------------------------
// look_at_view_matrix - fixed-point look-at camera view matrix
// Builds the rotation rows s, u, -f and the translations of a view matrix
// from an eye position, a target point and an up direction, all Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per camera: eye, target and up, each three signed
//   Q16.16 words. out_ch returns one item per input: side, camera up and back
//   rows and the three saturated translations. Items leave in input order.
//   From acceptance to out_ch.valid an item passes two normalizers in series,
//   54 stages each (5 scaling stages, 31 root stages, 1 setup stage and 17
//   quotient stages), two 2-stage cross products and a 4-stage dot and
//   rounding tail. One item is accepted every cycle while out_ch is drained.
//   All stages advance together; the last stage is the output register.
//   When out_ch stalls with a result waiting, the whole pipe holds and
//   in_ch.ready drops; while that register is empty the pipe keeps moving and
//   in_ch.ready stays high, so an empty output register never holds the pipe.
//   Reset (synchronous, active high) empties the pipe: every stage valid
//   clears, so no result appears until new items are accepted.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic            clk,
  input  logic            rst,
  lav_in_if.sink          in_ch,
  lav_out_if.source       out_ch
);
  import lav_pkg::*;

  // advance every stage unless a finished result is held
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // target - eye, exact at 33 bits
  logic signed [32:0] dx, dy, dz;
  assign dx = 33'(in_ch.target_x) - 33'(in_ch.eye_x);
  assign dy = 33'(in_ch.target_y) - 33'(in_ch.eye_y);
  assign dz = 33'(in_ch.target_z) - 33'(in_ch.eye_z);

  // forward and normalized up in parallel; the eye splits across the two
  logic          vf, vu;
  uvec_t         f_n, nu_n;
  logic [63:0]   eye_xy;
  logic [31:0]   eye_zn;

  lav_norm #(.W(33), .SW(64)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (in_ch.valid && in_ch.ready),
    .vx       (dx),
    .vy       (dy),
    .vz       (dz),
    .side_in  ({in_ch.eye_x, in_ch.eye_y}),
    .vout     (vf),
    .r        (f_n),
    .side_out (eye_xy)
  );

  lav_norm #(.W(32), .SW(32)) u_norm_up (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (in_ch.valid && in_ch.ready),
    .vx       (in_ch.up_x),
    .vy       (in_ch.up_y),
    .vz       (in_ch.up_z),
    .side_in  (in_ch.eye_z),
    .vout     (vu),
    .r        (nu_n),
    .side_out (eye_zn)
  );

  evec_t eye_n;
  assign eye_n = {eye_xy, eye_zn};

  // f x nu at Q32.32
  logic  vc1;
  cvec_t c1;
  uvec_t f_c1;
  evec_t eye_c1;

  lav_cross #(.SW($bits(uvec_t) + $bits(evec_t))) u_cross_side (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (vf),
    .a        (f_n),
    .b        (nu_n),
    .side_in  ({f_n, eye_n}),
    .vout     (vc1),
    .c        (c1),
    .side_out ({f_c1, eye_c1})
  );

  // side vector
  logic  vs;
  uvec_t s_n, f_s;
  evec_t eye_s;

  lav_norm #(.W(35), .SW($bits(uvec_t) + $bits(evec_t))) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (vc1),
    .vx       (c1.x),
    .vy       (c1.y),
    .vz       (c1.z),
    .side_in  ({f_c1, eye_c1}),
    .vout     (vs),
    .r        (s_n),
    .side_out ({f_s, eye_s})
  );

  // s x f, rounded to the camera up vector in the tail
  logic  vc2;
  cvec_t c2;
  uvec_t s_c2, f_c2;
  evec_t eye_c2;

  lav_cross #(.SW(2 * $bits(uvec_t) + $bits(evec_t))) u_cross_up (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (vs),
    .a        (s_n),
    .b        (f_s),
    .side_in  ({s_n, f_s, eye_s}),
    .vout     (vc2),
    .c        (c2),
    .side_out ({s_c2, f_c2, eye_c2})
  );

  res_t res;

  lav_xform u_xform (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (vc2),
    .c    (c2),
    .s    (s_c2),
    .f    (f_c2),
    .eye  (eye_c2),
    .vout (out_ch.valid),
    .res  (res)
  );

  assign out_ch.side_x        = res.side_x;
  assign out_ch.side_y        = res.side_y;
  assign out_ch.side_z        = res.side_z;
  assign out_ch.camera_up_x   = res.camera_up_x;
  assign out_ch.camera_up_y   = res.camera_up_y;
  assign out_ch.camera_up_z   = res.camera_up_z;
  assign out_ch.back_x        = res.back_x;
  assign out_ch.back_y        = res.back_y;
  assign out_ch.back_z        = res.back_z;
  assign out_ch.shift_side    = res.shift_side;
  assign out_ch.shift_up      = res.shift_up;
  assign out_ch.shift_forward = res.shift_forward;

`ifndef NO_ASSERTIONS
  // the two parallel normalizers stay in lockstep
  a_norm_lockstep: assert property (@(posedge clk) disable iff (rst) vf == vu)
    else $error("forward and up normalizers out of step");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  // back row is a unit vector component
  a_back_unit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ($signed(out_ch.back_x) <= 32'sd65536 &&
                      $signed(out_ch.back_x) >= -32'sd65536))
    else $error("back_x outside unit range");
`endif

endmodule
